// File: hdl/swp_pkg.sv
package swp_pkg;

   // 95th percentile rank is (held-1)*PCT_NUM/PCT_DEN
   localparam int unsigned PCT_NUM = 95;
   localparam int unsigned PCT_DEN = 100;
   // remainder of the running rank division, always below PCT_DEN
   localparam int unsigned REM_BITS = 7;

   // cells per first-level group of the select tree
   localparam int unsigned GROUP_CELLS = 32;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_UPDATE = 4'b0010,
      ST_GATHER = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // broadcast to every cell of the sorted chain
   typedef struct packed {
      logic apply;   // cells take their next value this cycle
      logic clear;   // empty the chain
      logic evict;   // window full: drop the oldest sample
   } cell_ctl_type;

   // per-cell status seen by both neighbors
   typedef struct packed {
      logic occ;     // cell holds a sample
      logic lt;      // held sample is below the incoming one
      logic past;    // cell sits at or after the evicted slot
   } cell_flag_type;

endpackage

// File: hdl/swp_ram.sv
module swp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/swp_cell.sv
module swp_cell #(
   parameter int WINDOW_DEPTH = 256,
   parameter int SAMPLE_BITS = 32,
   localparam int AGE_BITS = $clog2(WINDOW_DEPTH)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  swp_pkg::cell_ctl_type    ctl,
   input  logic [SAMPLE_BITS-1:0]   sample,
   input  logic [SAMPLE_BITS-1:0]   v_old,
   input  logic [SAMPLE_BITS-1:0]   left_val,
   input  logic [AGE_BITS-1:0]      left_age,
   input  swp_pkg::cell_flag_type   left_flag,
   input  logic [SAMPLE_BITS-1:0]   right_val,
   input  logic [AGE_BITS-1:0]      right_age,
   input  swp_pkg::cell_flag_type   right_flag,
   output logic [SAMPLE_BITS-1:0]   val,
   output logic [AGE_BITS-1:0]      age,
   output swp_pkg::cell_flag_type   flag
);

   localparam logic [AGE_BITS-1:0] AGE_MAX = AGE_BITS'(WINDOW_DEPTH - 1);

   logic [SAMPLE_BITS-1:0] val_ff, val_in;
   logic [AGE_BITS-1:0]    age_ff, age_in;
   logic                   occ_ff, occ_in;

   // chain entry at this position once the oldest is removed
   logic [SAMPLE_BITS-1:0] sel_val;
   logic [AGE_BITS-1:0]    sel_age;
   logic                   sel_occ, sel_lt;
   // chain entry one position lower once the oldest is removed
   logic [SAMPLE_BITS-1:0] low_val;
   logic [AGE_BITS-1:0]    low_age;
   logic                   low_occ, low_lt;

   // own status; equal samples sit in age order, so the oldest ends its tie run
   always_comb begin
      flag.occ  = occ_ff;
      flag.lt   = occ_ff && (val_ff < sample);
      flag.past = ctl.evict && occ_ff && ((val_ff > v_old) || (age_ff == AGE_MAX));
   end

   // eviction closes the gap by taking from the right neighbor
   always_comb begin
      if (flag.past) begin
         sel_val = right_val;
         sel_age = right_age;
         sel_occ = right_flag.occ;
         sel_lt  = right_flag.lt;
      end else begin
         sel_val = val_ff;
         sel_age = age_ff;
         sel_occ = occ_ff;
         sel_lt  = flag.lt;
      end
      if (left_flag.past) begin
         low_val = val_ff;
         low_age = age_ff;
         low_occ = occ_ff;
         low_lt  = flag.lt;
      end else begin
         low_val = left_val;
         low_age = left_age;
         low_occ = left_flag.occ;
         low_lt  = left_flag.lt;
      end
   end

   // insertion: smaller entries stay, the new word lands at the boundary,
   // larger entries move one position up
   always_comb begin
      if (sel_lt) begin
         val_in = sel_val;
         age_in = sel_age + AGE_BITS'(1);
         occ_in = sel_occ;
      end else if (low_lt) begin
         val_in = sample;
         age_in = '0;
         occ_in = 1'b1;
      end else begin
         val_in = low_val;
         age_in = low_age + AGE_BITS'(1);
         occ_in = low_occ;
      end
      if (ctl.clear) begin
         occ_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else if (ctl.apply) begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.apply) begin
         val_ff <= val_in;
         age_ff <= age_in;
      end
   end

   assign val = val_ff;
   assign age = age_ff;

endmodule

// File: hdl/swp_select.sv
module swp_select #(
   parameter int WINDOW_DEPTH = 256,
   parameter int SAMPLE_BITS = 32,
   localparam int IDX_BITS = $clog2(WINDOW_DEPTH)
) (
   input  logic                   clock,
   input  logic                   load,
   input  logic [SAMPLE_BITS-1:0] cell_val [WINDOW_DEPTH],
   input  logic [WINDOW_DEPTH-1:0] cell_occ,
   input  logic [IDX_BITS-1:0]    rank_med,
   input  logic [IDX_BITS-1:0]    rank_p95,
   output logic [SAMPLE_BITS-1:0] median,
   output logic [SAMPLE_BITS-1:0] pct95
);

   localparam int G = swp_pkg::GROUP_CELLS;
   localparam int NGROUP = (WINDOW_DEPTH + G - 1) / G;

   logic [SAMPLE_BITS-1:0] grp_med_ff [NGROUP];
   logic [SAMPLE_BITS-1:0] grp_p95_ff [NGROUP];
   logic [SAMPLE_BITS-1:0] grp_med_in [NGROUP];
   logic [SAMPLE_BITS-1:0] grp_p95_in [NGROUP];

   // first level: each group picks its cell at the wanted rank, if any
   always_comb begin
      for (int g = 0; g < NGROUP; g++) begin
         grp_med_in[g] = '0;
         grp_p95_in[g] = '0;
         for (int k = 0; k < G; k++) begin
            if (g * G + k < WINDOW_DEPTH) begin
               if (cell_occ[g * G + k] && (rank_med == IDX_BITS'(g * G + k))) begin
                  grp_med_in[g] = grp_med_in[g] | cell_val[g * G + k];
               end
               if (cell_occ[g * G + k] && (rank_p95 == IDX_BITS'(g * G + k))) begin
                  grp_p95_in[g] = grp_p95_in[g] | cell_val[g * G + k];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_med_ff <= grp_med_in;
         grp_p95_ff <= grp_p95_in;
      end
   end

   // second level: at most one group is nonzero
   always_comb begin
      median = '0;
      pct95  = '0;
      for (int g = 0; g < NGROUP; g++) begin
         median = median | grp_med_ff[g];
         pct95  = pct95 | grp_p95_ff[g];
      end
   end

endmodule

// File: hdl/sliding_window_percentiles.sv
// Sliding-window median and 95th percentile of timing samples.
//
// Request channel (req_valid / req_stall): one word carries req_clear and
// req_sample. With req_clear high the window is emptied and the sample is
// dropped; otherwise the sample joins the window, replacing the oldest one
// once WINDOW_DEPTH samples are held.
// Response channel (rsp_valid / rsp_stall): exactly one word per request,
// holding the sample count and the samples at sorted rank (held-1)/2 and
// (held-1)*95/100. An empty window answers with zeros.
// Flow: an accepted request passes the states UPDATE, GATHER and FINISH:
// the sorted cell chain updates (fed by the ring read of the oldest sample),
// then the first level of the two-level registered rank select loads, then
// the response register loads. req_stall stays high until the response is
// loaded, so the next request is taken only after that.
// While the response register is full and stalled, a finished result waits
// and req_stall stays high; nothing is dropped.
// Reset empties the window at once; no clearing pass is needed.
module sliding_window_percentiles #(
   parameter int WINDOW_DEPTH = 256,
   parameter int SAMPLE_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_clear,
   input  logic [SAMPLE_BITS-1:0]            req_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [SAMPLE_BITS-1:0]            rsp_median,
   output logic [SAMPLE_BITS-1:0]            rsp_pct95,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0] rsp_held
);

   localparam int IDX_BITS = $clog2(WINDOW_DEPTH);
   localparam int CNT_BITS = $clog2(WINDOW_DEPTH + 1);
   localparam int REM_BITS = swp_pkg::REM_BITS;
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(WINDOW_DEPTH);
   localparam logic [IDX_BITS-1:0] LAST_SLOT = IDX_BITS'(WINDOW_DEPTH - 1);

   swp_pkg::state_type state_ff, state_in;

   logic                   accept;
   logic                   clear_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;
   logic                   evict_ff;
   logic [IDX_BITS-1:0]    slot_ff;
   logic [CNT_BITS-1:0]    count_ff;
   logic [IDX_BITS-1:0]    q95_ff;
   logic [REM_BITS-1:0]    r95_ff;
   logic [REM_BITS:0]      r95_sum;
   logic [CNT_BITS-1:0]    count_less;
   logic [IDX_BITS-1:0]    rank_med;
   logic [SAMPLE_BITS-1:0] v_old;
   logic                   rsp_load;

   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_median_ff, rsp_pct95_ff;
   logic [CNT_BITS-1:0]    rsp_held_ff;
   logic [SAMPLE_BITS-1:0] sel_median, sel_pct95;

   swp_pkg::cell_ctl_type  cell_ctl;
   logic [SAMPLE_BITS-1:0] cell_val [WINDOW_DEPTH];
   logic [IDX_BITS-1:0]    cell_age [WINDOW_DEPTH];
   swp_pkg::cell_flag_type cell_flag [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] cell_occ;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != swp_pkg::ST_IDLE);
   assign rsp_load  = (state_ff == swp_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swp_pkg::ST_IDLE: begin
            if (accept) state_in = swp_pkg::ST_UPDATE;
         end
         swp_pkg::ST_UPDATE: begin
            state_in = swp_pkg::ST_GATHER;
         end
         swp_pkg::ST_GATHER: begin
            state_in = swp_pkg::ST_FINISH;
         end
         swp_pkg::ST_FINISH: begin
            if (rsp_load) state_in = swp_pkg::ST_IDLE;
         end
         default: begin
            state_in = swp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= swp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // request word, kept for the chain update
   always_ff @(posedge clock) begin
      if (accept) begin
         clear_ff  <= req_clear;
         sample_ff <= req_sample;
         evict_ff  <= !req_clear && (count_ff == FULL_COUNT);
      end
   end

   // ring position, fill count and running 95th rank (quotient and remainder)
   assign r95_sum = {1'b0, r95_ff} + (REM_BITS + 1)'(swp_pkg::PCT_NUM);

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         count_ff <= '0;
         q95_ff   <= '0;
         r95_ff   <= '0;
      end else if (accept) begin
         if (req_clear) begin
            slot_ff  <= '0;
            count_ff <= '0;
            q95_ff   <= '0;
            r95_ff   <= '0;
         end else begin
            slot_ff <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + IDX_BITS'(1);
            if (count_ff != FULL_COUNT) begin
               count_ff <= count_ff + CNT_BITS'(1);
               if (count_ff != '0) begin
                  if (r95_sum >= (REM_BITS + 1)'(swp_pkg::PCT_DEN)) begin
                     r95_ff <= REM_BITS'(r95_sum - (REM_BITS + 1)'(swp_pkg::PCT_DEN));
                     q95_ff <= q95_ff + IDX_BITS'(1);
                  end else begin
                     r95_ff <= r95_sum[REM_BITS-1:0];
                  end
               end
            end
         end
      end
   end

   assign count_less = count_ff - CNT_BITS'(1);
   assign rank_med   = IDX_BITS'(count_less >> 1);

   // ring of held samples; the slot read here is the oldest once full
   swp_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (accept && !req_clear),
      .wr_addr (slot_ff),
      .wr_data (req_sample),
      .rd_en   (accept),
      .rd_addr (slot_ff),
      .rd_data (v_old)
   );

   // sorted chain of cells, ascending from cell 0
   always_comb begin
      cell_ctl.apply = (state_ff == swp_pkg::ST_UPDATE);
      cell_ctl.clear = clear_ff;
      cell_ctl.evict = evict_ff;
   end

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] l_val, r_val;
      logic [IDX_BITS-1:0]    l_age, r_age;
      swp_pkg::cell_flag_type l_flag, r_flag;

      if (i == 0) begin : g_lo
         // below the chain: always smaller, never evicted
         assign l_val  = '0;
         assign l_age  = '0;
         assign l_flag = '{occ: 1'b0, lt: 1'b1, past: 1'b0};
      end else begin : g_lo
         assign l_val  = cell_val[i-1];
         assign l_age  = cell_age[i-1];
         assign l_flag = cell_flag[i-1];
      end

      if (i == WINDOW_DEPTH - 1) begin : g_hi
         // above the chain: empty
         assign r_val  = '0;
         assign r_age  = '0;
         assign r_flag = '{occ: 1'b0, lt: 1'b0, past: 1'b0};
      end else begin : g_hi
         assign r_val  = cell_val[i+1];
         assign r_age  = cell_age[i+1];
         assign r_flag = cell_flag[i+1];
      end

      swp_cell #(
         .WINDOW_DEPTH (WINDOW_DEPTH),
         .SAMPLE_BITS  (SAMPLE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (cell_ctl),
         .sample     (sample_ff),
         .v_old      (v_old),
         .left_val   (l_val),
         .left_age   (l_age),
         .left_flag  (l_flag),
         .right_val  (r_val),
         .right_age  (r_age),
         .right_flag (r_flag),
         .val        (cell_val[i]),
         .age        (cell_age[i]),
         .flag       (cell_flag[i])
      );

      assign cell_occ[i] = cell_flag[i].occ;
   end

   // rank select over the chain
   swp_select #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_select (
      .clock    (clock),
      .load     (state_ff == swp_pkg::ST_GATHER),
      .cell_val (cell_val),
      .cell_occ (cell_occ),
      .rank_med (rank_med),
      .rank_p95 (q95_ff),
      .median   (sel_median),
      .pct95    (sel_pct95)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_median_ff <= sel_median;
         rsp_pct95_ff  <= sel_pct95;
         rsp_held_ff   <= count_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;
   assign rsp_pct95  = rsp_pct95_ff;
   assign rsp_held   = rsp_held_ff;

   // checks
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == swp_pkg::ST_FINISH))
      else $error("response raised outside the finish step");

   a_accept_starts_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == swp_pkg::ST_UPDATE))
      else $error("accepted word did not start a chain update");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= FULL_COUNT) && (r95_ff < REM_BITS'(swp_pkg::PCT_DEN)))
      else $error("fill count or rank remainder out of range");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_held_ff == '0)) |-> ((rsp_median_ff == '0) && (rsp_pct95_ff == '0)))
      else $error("empty window reported a nonzero sample");

   a_full_evicts: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_clear && (count_ff == FULL_COUNT)) |=> (count_ff == FULL_COUNT))
      else $error("full window lost its fill count");

endmodule

// File: dv/sliding_window_percentiles_tb.sv
module sliding_window_percentiles_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW_DEPTH = 256;
   localparam int SAMPLE_BITS = 32;
   localparam int HELD_BITS = $clog2(WINDOW_DEPTH + 1);
   localparam int CYCLE_LIMIT = 300000;

   // value spread of the random samples
   typedef enum int {
      SPREAD_FULL,
      SPREAD_NARROW,
      SPREAD_TOP,
      SPREAD_RAMP
   } spread_type;

   // expected contents of one response word
   typedef struct {
      logic [SAMPLE_BITS-1:0] median;
      logic [SAMPLE_BITS-1:0] pct95;
      logic [HELD_BITS-1:0]   held;
   } window_stats_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_clear = 1'b0;
   logic [SAMPLE_BITS-1:0] req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [SAMPLE_BITS-1:0] rsp_median;
   logic [SAMPLE_BITS-1:0] rsp_pct95;
   logic [HELD_BITS-1:0]   rsp_held;

   // shadow of the window: ring in arrival order plus a sorted copy
   logic [SAMPLE_BITS-1:0] ring [WINDOW_DEPTH];
   logic [SAMPLE_BITS-1:0] sorted_held [$];
   int unsigned            ring_slot = 0;
   int unsigned            ring_fill = 0;

   window_stats_type       pending_stats [$];

   int          send_gap_pct = 0;
   int          rsp_stall_pct = 0;
   spread_type  spread = SPREAD_FULL;
   logic [SAMPLE_BITS-1:0] ramp_value = '0;

   int unsigned mismatch_count = 0;
   int unsigned words_sent = 0;
   int unsigned clears_sent = 0;
   int unsigned results_checked = 0;
   int unsigned evictions = 0;
   int unsigned held_peak = 0;
   int unsigned cycle_count = 0;

   sliding_window_percentiles #(
      .WINDOW_DEPTH(WINDOW_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_clear(req_clear),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_median(rsp_median),
      .rsp_pct95(rsp_pct95),
      .rsp_held(rsp_held)
   );

   always #6 clock = ~clock;

   // update the shadow window with one word and return the stats it yields
   function automatic window_stats_type track_window(input logic clr,
                                                     input logic [SAMPLE_BITS-1:0] smp);
      window_stats_type       stats;
      int unsigned            pos;
      int unsigned            n;
      logic [SAMPLE_BITS-1:0] oldest;
      stats.median = '0;
      stats.pct95 = '0;
      if (clr) begin
         sorted_held.delete();
         ring_slot = 0;
         ring_fill = 0;
      end else begin
         if (ring_fill == WINDOW_DEPTH) begin
            // full: drop one copy of the oldest value from the sorted copy
            oldest = ring[ring_slot];
            pos = 0;
            while (sorted_held[pos] != oldest) pos++;
            sorted_held.delete(pos);
            evictions++;
         end else begin
            ring_fill++;
         end
         ring[ring_slot] = smp;
         ring_slot = (ring_slot + 1) % WINDOW_DEPTH;
         pos = 0;
         while (pos < sorted_held.size() && sorted_held[pos] <= smp) pos++;
         sorted_held.insert(pos, smp);
      end
      n = ring_fill;
      if (n > held_peak) held_peak = n;
      if (n > 0) begin
         stats.median = sorted_held[(n - 1) / 2];
         stats.pct95 = sorted_held[((n - 1) * swp_pkg::PCT_NUM) / swp_pkg::PCT_DEN];
      end
      stats.held = HELD_BITS'(n);
      return stats;
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] random_sample();
      logic [SAMPLE_BITS-1:0] v;
      case (spread)
         SPREAD_NARROW: begin
            v = $urandom_range(15);
         end
         SPREAD_TOP: begin
            v = {SAMPLE_BITS{1'b1}} - $urandom_range(15);
         end
         SPREAD_RAMP: begin
            ramp_value = ramp_value + $urandom_range(3);
            v = ramp_value;
         end
         default: begin
            v = $urandom;
         end
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   // send one word; called and returns at a falling edge
   task automatic send_word(input logic clr, input logic [SAMPLE_BITS-1:0] smp);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid = 1'b0;
         req_clear = 1'($urandom_range(1));
         req_sample = $urandom;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_clear = clr;
      req_sample = smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_stats.insert(pending_stats.size(), track_window(clr, smp));
      words_sent++;
      if (clr) clears_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid = 1'b0;
      while (pending_stats.size() != 0) @(negedge clock);
   endtask

   // random words, a clear now and then, spread changing in runs
   task automatic run_random(input int count, input int clear_one_in);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(47) == 0) spread = spread_type'($urandom_range(3));
         if ($urandom_range(clear_one_in - 1) == 0)
            send_word(1'b1, $urandom);
         else
            send_word(1'b0, random_sample());
      end
   endtask

   // clear on an empty window, then clear a window holding one sample
   task automatic test_empty_window();
      send_word(1'b1, 32'h0000_0000);
      send_word(1'b1, 32'hFFFF_FFFF);
      send_word(1'b0, 32'd5);
      send_word(1'b1, 32'd9);
   endtask

   // sample extremes, bit patterns and duplicates
   task automatic test_extremes();
      send_word(1'b0, 32'h0000_0000);
      send_word(1'b0, 32'hFFFF_FFFF);
      send_word(1'b0, 32'h0000_0000);
      send_word(1'b0, 32'hFFFF_FFFF);
      send_word(1'b0, 32'h7FFF_FFFF);
      send_word(1'b0, 32'h8000_0000);
      send_word(1'b0, 32'hAAAA_AAAA);
      send_word(1'b0, 32'h5555_5555);
      send_word(1'b0, 32'h0000_0001);
      send_word(1'b0, 32'hFFFF_FFFE);
      for (int i = 0; i < 5; i++) send_word(1'b0, 32'd42);
      send_word(1'b1, 32'd0);
   endtask

   // fill past the window depth so the oldest samples get overwritten
   task automatic test_fill_and_wrap();
      send_word(1'b1, 32'd0);
      run_random(330, 1000);
   endtask

   // frequent clears and a full drain midway
   task automatic test_short_windows();
      send_word(1'b1, $urandom);
      run_random(160, 40);
      wait_for_drain();
      run_random(160, 40);
   endtask

   task automatic test_steady_stream();
      send_word(1'b1, 32'd0);
      run_random(300, 700);
   endtask

   // receiver stall, changed at the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // compare each accepted response word with the oldest expectation
   always @(posedge clock) begin : check_results
      window_stats_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_stats.size() == 0) begin
            report_mismatch($sformatf("response word with none expected (held %0d)",
                                      rsp_held));
         end else begin
            want = pending_stats.pop_front();
            if (rsp_median !== want.median)
               report_mismatch($sformatf("median expected %0d got %0d",
                                         want.median, rsp_median));
            if (rsp_pct95 !== want.pct95)
               report_mismatch($sformatf("pct95 expected %0d got %0d",
                                         want.pct95, rsp_pct95));
            if (rsp_held !== want.held)
               report_mismatch($sformatf("held expected %0d got %0d",
                                         want.held, rsp_held));
            results_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, pending_stats.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (5) @(negedge clock);
      reset = 1'b0;

      // sender idles lightly, receiver stalls heavily
      send_gap_pct = 34;
      rsp_stall_pct = 88;
      test_empty_window();
      test_extremes();
      test_fill_and_wrap();

      // the other way round
      send_gap_pct = 88;
      rsp_stall_pct = 34;
      test_short_windows();

      // back to back
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      test_steady_stream();

      wait_for_drain();
      repeat (8) @(negedge clock);

      $display("sent %0d words (%0d clears) under three idle mixes, %0d responses compared",
               words_sent, clears_sent, results_checked);
      $display("window peaked at %0d samples with %0d overwrites of the oldest sample",
               held_peak, evictions);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: sliding_window_percentiles.f
hdl/swp_pkg.sv
hdl/swp_ram.sv
hdl/swp_cell.sv
hdl/swp_select.sv
hdl/sliding_window_percentiles.sv
dv/sliding_window_percentiles_tb.sv
